/* sv/swor_pkg.sv */
// shared types and constants for the sentence word order reverser
package swor_pkg;

  // width of stored counts and store addresses (each store bank holds up to 64 bytes)
  localparam int CNT_W = 7;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_END   = 8'd0;

  // one finished sentence handed from front to back
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] start;
    logic             ovf;
  } swor_job_t;

  // store write request from the front
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [CNT_W-1:0] addr;
    logic [CNT_W-1:0] link;
    logic [7:0]       data;
  } swor_wr_t;

  // back status toward the queue and the top level
  typedef struct packed {
    logic active;
    logic take;
  } swor_stat_t;

endpackage

/* sv/swor_front.sv */
// front part: classifies incoming bytes, fills the store, queues finished sentences
module swor_front import swor_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output swor_wr_t   wr_o,
  output logic       push_o,
  output swor_job_t  job_o
);

  logic             bank_q, bank_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] start_q, start_d;
  logic             ovf_q, ovf_d;
  logic             sp_q, sp_d;
  logic             is_end, is_dup_sp, is_full;

  // classify the request
  assign is_end    = (byte_i == CH_END);
  assign is_dup_sp = (byte_i == CH_SPACE) && sp_q;
  assign is_full   = (count_q == CNT_W'(MAX_CHARS));

  // job for the back part on the terminator
  assign push_o      = accept_i && is_end;
  assign job_o.bank  = bank_q;
  assign job_o.count = count_q;
  assign job_o.start = start_q;
  assign job_o.ovf   = ovf_q;

  // store write: byte plus start of the segment before it (used at spaces)
  assign wr_o.en   = accept_i && !is_end && !is_dup_sp && !is_full;
  assign wr_o.bank = bank_q;
  assign wr_o.addr = count_q;
  assign wr_o.link = start_q;
  assign wr_o.data = byte_i;

  // next state
  always_comb begin
    bank_d  = bank_q;
    count_d = count_q;
    start_d = start_q;
    ovf_d   = ovf_q;
    sp_d    = sp_q;
    if (accept_i) begin
      priority if (is_end) begin
        bank_d  = !bank_q;
        count_d = '0;
        start_d = '0;
        ovf_d   = 1'b0;
        sp_d    = 1'b0;
      end else if (is_dup_sp) begin
        sp_d = sp_q;
      end else if (is_full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
        sp_d    = (byte_i == CH_SPACE);
        if (byte_i == CH_SPACE) begin
          start_d = count_q + CNT_W'(1);
        end
      end
    end
  end

  // loading state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      count_q <= '0;
      start_q <= '0;
      ovf_q   <= 1'b0;
      sp_q    <= 1'b0;
    end else begin
      bank_q  <= bank_d;
      count_q <= count_d;
      start_q <= start_d;
      ovf_q   <= ovf_d;
      sp_q    <= sp_d;
    end
  end

endmodule

/* sv/swor_queue.sv */
// two-entry job queue between the front and back parts
module swor_queue import swor_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  swor_job_t  job_i,
  input  logic       pop_i,
  output swor_job_t  job_o,
  output logic       empty_o,
  output logic [1:0] cnt_o
);

  swor_job_t  slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign job_o   = slot_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign cnt_o   = cnt_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* sv/swor_back.sv */
// back part: double-banked store and the backward segment walk that emits results
module swor_back import swor_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  swor_wr_t   wr_i,
  input  swor_job_t  job_i,
  input  logic       empty_i,
  output swor_stat_t stat_o,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o,
  output logic       ovf_o
);

  localparam int AW    = $clog2(MAX_CHARS);
  localparam int DEPTH = 2 * (2 ** AW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_LINK,
    ST_WAIT
  } state_e;

  // store word: link to previous segment start, then the byte
  logic [AW+7:0]    mem [DEPTH];
  logic [AW+7:0]    rdata_q;
  logic [AW:0]      raddr;

  state_e           state_q, state_d;
  logic             bank_q, bank_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic [CNT_W-1:0] seg_start_q, seg_start_d;
  logic [CNT_W-1:0] seg_end_q, seg_end_d;
  logic             jovf_q, jovf_d;
  logic             val_q, val_d;
  logic             last_q, last_d;
  logic             zero_q, zero_d;
  logic             ovf_q, ovf_d;
  logic             take;
  logic [CNT_W-1:0] link_prev;

  assign take          = (state_q == ST_IDLE) && !empty_i;
  assign stat_o.take   = take;
  assign stat_o.active = (state_q != ST_IDLE);
  assign link_prev     = seg_start_q - CNT_W'(1);

  // store write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[{wr_i.bank, wr_i.addr[AW-1:0]}] <= {wr_i.link[AW-1:0], wr_i.data};
    end
  end

  // store read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  // read address
  always_comb begin
    unique case (state_q)
      ST_LINK: raddr = {bank_q, link_prev[AW-1:0]};
      default: raddr = {bank_q, cur_q};
    endcase
  end

  // walk control
  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    cur_d       = cur_q;
    seg_start_d = seg_start_q;
    seg_end_d   = seg_end_q;
    jovf_d      = jovf_q;
    val_d       = 1'b0;
    last_d      = 1'b0;
    zero_d      = 1'b0;
    ovf_d       = jovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          bank_d      = job_i.bank;
          jovf_d      = job_i.ovf;
          seg_start_d = job_i.start;
          seg_end_d   = job_i.count;
          cur_d       = job_i.start[AW-1:0];
          priority if (job_i.count == '0) begin
            // empty sentence gives one zero byte
            val_d  = 1'b1;
            last_d = 1'b1;
            zero_d = 1'b1;
            ovf_d  = job_i.ovf;
          end else if (job_i.start == job_i.count) begin
            state_d = ST_LINK;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        val_d = 1'b1;
        if ((CNT_W'(cur_q) + CNT_W'(1)) == seg_end_q) begin
          if (seg_start_q == '0) begin
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_LINK;
          end
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end
      ST_LINK: begin
        // emit the separating space and fetch the previous segment start
        val_d     = 1'b1;
        seg_end_d = link_prev;
        if (link_prev == '0) begin
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        seg_start_d = CNT_W'(rdata_q[AW+7:8]);
        cur_d       = rdata_q[AW+7:8];
        state_d     = ST_EMIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= 1'b0;
      cur_q       <= '0;
      seg_start_q <= '0;
      seg_end_q   <= '0;
      jovf_q      <= 1'b0;
      val_q       <= 1'b0;
      last_q      <= 1'b0;
      zero_q      <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      cur_q       <= cur_d;
      seg_start_q <= seg_start_d;
      seg_end_q   <= seg_end_d;
      jovf_q      <= jovf_d;
      val_q       <= val_d;
      last_q      <= last_d;
      zero_q      <= zero_d;
      ovf_q       <= ovf_d;
    end
  end

  // result ports
  assign valid_o = val_q;
  assign last_o  = last_q;
  assign ovf_o   = ovf_q;
  assign byte_o  = zero_q ? CH_END : rdata_q[7:0];

endmodule

/* sv/sentence_word_order_reverser.sv */
// top level of the sentence word order reverser
//
// A sentence enters one byte per request (start high while busy is low); byte 0
// ends it. Loading gives no result. Runs of spaces are stored as one space, and
// bytes beyond MAX_CHARS are dropped with overflow_o set on every result of that
// sentence. After the terminator the words come out in reverse order on byte_out_o,
// one byte per cycle apart from the gaps after spaces, marked by valid_o, with
// last_o on the final byte; the receiver cannot hold results off. The terminator's
// job passes through the job queue to the back part, which reads each byte through
// the registered store port (the zero byte of an empty sentence needs no read).
// After each space that is not the first stored byte, valid_o is low while the
// store read fetches the start of the previous word. The store has two banks, so
// the next sentence can load while the previous one is still emitted; busy is high
// only while two finished sentences are waiting or being emitted.
module sentence_word_order_reverser import swor_pkg::*; #(
  parameter int MAX_CHARS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] byte_in_i,
  output logic       valid_o,
  output logic [7:0] byte_out_o,
  output logic       last_o,
  output logic       overflow_o
);

  swor_wr_t   wr;
  swor_job_t  push_job, pop_job;
  swor_stat_t stat;
  logic       push, q_empty, accept;
  logic [1:0] q_cnt;
  logic [1:0] pending;

  // two sentences in flight fill both store banks
  assign pending = q_cnt + {1'b0, stat.active};
  assign busy    = (pending >= 2'd2);
  assign accept  = start && !busy;

  swor_front #(.MAX_CHARS(MAX_CHARS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (byte_in_i),
    .wr_o    (wr),
    .push_o  (push),
    .job_o   (push_job)
  );

  swor_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (stat.take),
    .job_o  (pop_job),
    .empty_o(q_empty),
    .cnt_o  (q_cnt)
  );

  swor_back #(.MAX_CHARS(MAX_CHARS)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .job_i  (pop_job),
    .empty_i(q_empty),
    .stat_o (stat),
    .valid_o(valid_o),
    .byte_o (byte_out_o),
    .last_o (last_o),
    .ovf_o  (overflow_o)
  );

  // queue never overfilled
  assert property (@(posedge clk_i) disable iff (!rst_ni) (q_cnt == 2'd2) |-> !push)
    else $error("job queue overflow");

  // back only takes a job that exists
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat.take |-> !q_empty)
    else $error("job taken from empty queue");

  // at most two sentences outstanding, one per store bank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (q_cnt + {1'b0, stat.active}) <= 2'd2)
    else $error("store banks oversubscribed");

  // no store write lands while both banks are in use
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !wr.en)
    else $error("store write while busy");

endmodule
